### design/cts_pkg.sv
// Shared types and codes for the coordinate table search block.
// Used by cts_engine and coordinate_table_search; depends on nothing.
package cts_pkg;

  // Fixed widths of the word fields at the ports.
  localparam int PORT_COORD_BITS = 16;
  localparam int INDEX_BITS      = 6;

  typedef enum logic [2:0] {
    REQ_PUSH       = 3'd0,
    REQ_GET        = 3'd1,
    REQ_PEEK       = 3'd2,
    REQ_RM_INDEX   = 3'd3,
    REQ_RM_OBJECT  = 3'd4,
    REQ_FIND       = 3'd5,
    REQ_FIRST_FREE = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_CLEAR,
    S_DONE
  } state_t;

  // Status and table flags that go with one finished result.
  typedef struct packed {
    status_t status;
    logic    full;
    logic    empty;
  } res_ctl_t;

endpackage

### design/cts_mem.sv
// Single-port synchronous memory holding the coordinate pairs.
// One access a cycle: a write, or a read whose data is registered.
module cts_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write has priority; otherwise the addressed entry is read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/cts_engine.sv
// Request sequencer: decodes a request, drives the table memory and
// scans it one entry a cycle. Depends on cts_pkg.
module cts_engine
  import cts_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [2:0]               req_type,
  input  logic [COORD_BITS-1:0]    key_x,
  input  logic [COORD_BITS-1:0]    key_y,
  input  logic [INDEX_BITS-1:0]    slot,
  input  logic                     out_free,
  output logic                     done,
  output res_ctl_t                 res_ctl,
  output logic [$clog2(DEPTH)-1:0] res_idx,
  output logic [COORD_BITS-1:0]    res_x,
  output logic [COORD_BITS-1:0]    res_y,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_addr,
  output logic [2*COORD_BITS-1:0]  mem_wdata,
  input  logic [2*COORD_BITS-1:0]  mem_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int WW = FW + INDEX_BITS;

  state_t          state, state_next;
  req_t            cur_req;
  req_t            new_req;
  logic [FW-1:0]   fill;
  logic [FW-1:0]   fill_m1;
  logic [FW-1:0]   iss;
  logic [FW-1:0]   clr;
  logic            rd_vld;
  logic [AW-1:0]   rd_idx;
  logic [COORD_BITS-1:0] kx, ky;
  status_t         res_status;
  logic [WW-1:0]   slot_w;
  logic [WW-1:0]   fill_w;
  logic            slot_ok;
  logic            tab_full;
  logic            tab_empty;
  logic            issue;
  logic            hit;
  logic            scan_miss;
  logic            accept;
  logic            clr_last;

  // Decode helpers shared by the state and datapath logic.
  always_comb begin
    new_req   = req_t'(req_type);
    slot_w    = {{FW{1'b0}}, slot};
    fill_w    = {{INDEX_BITS{1'b0}}, fill};
    slot_ok   = slot_w < fill_w;
    tab_full  = fill == FW'(DEPTH);
    tab_empty = fill == '0;
    fill_m1   = fill - 1'b1;
    issue     = iss < fill;
    hit       = rd_vld && (mem_rdata == {kx, ky});
    scan_miss = !rd_vld && !issue;
    accept    = (state == S_IDLE) && req_valid;
    clr_last  = (clr + 1'b1) == fill;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (new_req)
            REQ_GET: state_next = slot_ok ? S_READ : S_DONE;
            REQ_PEEK: state_next = tab_empty ? S_DONE : S_READ;
            REQ_RM_OBJECT, REQ_FIND, REQ_FIRST_FREE: state_next = S_SCAN;
            REQ_CLEAR: state_next = tab_empty ? S_DONE : S_CLEAR;
            REQ_PUSH, REQ_RM_INDEX: state_next = S_DONE;
          endcase
        end
      end
      S_READ:  state_next = S_DONE;
      S_SCAN:  if (hit || scan_miss) state_next = S_DONE;
      S_CLEAR: if (clr_last) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory port, handshake and result strobe.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '1;
    req_stall = state != S_IDLE;
    done      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (new_req)
            REQ_PUSH: begin
              mem_we    = !tab_full;
              mem_addr  = fill[AW-1:0];
              mem_wdata = {key_x, key_y};
            end
            REQ_GET: mem_addr = slot_w[AW-1:0];
            REQ_PEEK: mem_addr = fill_m1[AW-1:0];
            REQ_RM_INDEX: begin
              mem_we   = slot_ok;
              mem_addr = slot_w[AW-1:0];
            end
            default: mem_we = 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we   = cur_req == REQ_RM_OBJECT;
          mem_addr = rd_idx;
        end else begin
          mem_addr = iss[AW-1:0];
        end
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr[AW-1:0];
      end
      S_DONE: done = out_free;
      default: done = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN) && issue && !hit;
      if (accept && new_req == REQ_PUSH && !tab_full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Request, key and result registers.
  always_ff @(posedge clk) begin
    rd_idx <= iss[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur_req    <= new_req;
          kx         <= (new_req == REQ_FIRST_FREE) ? '1 : key_x;
          ky         <= (new_req == REQ_FIRST_FREE) ? '1 : key_y;
          iss        <= '0;
          clr        <= '0;
          res_x      <= '1;
          res_y      <= '1;
          res_idx    <= '0;
          res_status <= ST_OK;
          unique case (new_req)
            REQ_PUSH: begin
              if (tab_full) res_status <= ST_FULL;
              else res_idx <= fill[AW-1:0];
            end
            REQ_GET, REQ_RM_INDEX: begin
              if (!slot_ok) res_status <= ST_RANGE;
              else res_idx <= slot_w[AW-1:0];
            end
            REQ_PEEK: begin
              if (tab_empty) res_status <= ST_RANGE;
              else res_idx <= fill_m1[AW-1:0];
            end
            default: res_status <= ST_OK;
          endcase
        end
      end
      S_READ: begin
        res_x <= mem_rdata[2*COORD_BITS-1:COORD_BITS];
        res_y <= mem_rdata[COORD_BITS-1:0];
      end
      S_SCAN: begin
        if (issue && !hit) iss <= iss + 1'b1;
        if (hit) begin
          res_idx <= rd_idx;
        end else if (scan_miss) begin
          res_status <= (cur_req == REQ_RM_OBJECT) ? ST_RANGE : ST_NOTFOUND;
        end
      end
      S_CLEAR: clr <= clr + 1'b1;
      S_DONE: res_status <= res_status;
      default: res_status <= res_status;
    endcase
  end

  always_comb begin
    res_ctl.status = res_status;
    res_ctl.full   = tab_full;
    res_ctl.empty  = tab_empty;
  end

  // An accepted word always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state != S_IDLE)
    else $error("accepted word did not start a request");

  // The fill count moves only on an accepted push.
  a_fill_push_only: assert property (@(posedge clk) disable iff (rst)
    !(accept && new_req == REQ_PUSH) |=> $stable(fill))
    else $error("fill count changed without a push");

  // A failed request reports index zero.
  a_fail_idx_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status != ST_OK) |-> res_idx == '0)
    else $error("nonzero index on a failed request");

  // No memory write while a read result is pending or a result waits.
  a_no_write_late: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_READ && state != S_DONE))
    else $error("memory write in read or done state");

endmodule

### design/coordinate_table_search.sv
// Top level of the coordinate table search block: port formatting,
// output register. Depends on cts_pkg, cts_engine and cts_mem.
//
//   channel   direction  handshake            fields
//   request   in         req_valid/req_stall  req_type pos_x pos_y slot
//   response  out        rsp_valid/rsp_stall  status found_index out_x out_y
//                                             is_full is_empty
//
// Push and remove-index, and get, peek or clear that finish at once, go
// straight to the done state; get and peek that read an entry pass through
// the read state; find, first-free and remove-object scan up to the fill
// count, and clear overwrites each filled entry. The scans read one entry
// a cycle through the single memory port.
// Reset clears the fill count; entries at or past it are never read, so no
// clearing pass is needed. A stalled response holds in the output register
// while the next request is accepted; it finishes once the register frees.
module coordinate_table_search
  import cts_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [2:0]                        req_type,
  input  logic signed [PORT_COORD_BITS-1:0] pos_x,
  input  logic signed [PORT_COORD_BITS-1:0] pos_y,
  input  logic [INDEX_BITS-1:0]             slot,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [1:0]                        status,
  output logic [INDEX_BITS-1:0]             found_index,
  output logic signed [PORT_COORD_BITS-1:0] out_x,
  output logic signed [PORT_COORD_BITS-1:0] out_y,
  output logic                              is_full,
  output logic                              is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int PB = PORT_COORD_BITS;
  localparam int CB = COORD_BITS;

  logic [PB+CB-1:0]      px_ext, py_ext;
  logic [CB-1:0]         key_x, key_y;
  logic                  out_free;
  logic                  done;
  res_ctl_t              res_ctl;
  logic [AW-1:0]         res_idx;
  logic [CB-1:0]         res_x, res_y;
  logic [AW+INDEX_BITS-1:0] idx_ext;
  logic [CB+PB-1:0]      rx_ext, ry_ext;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [2*CB-1:0]       mem_wdata;
  logic [2*CB-1:0]       mem_rdata;

  // Port coordinates to table width, and table values back to port width.
  always_comb begin
    px_ext  = {{CB{pos_x[PB-1]}}, pos_x};
    py_ext  = {{CB{pos_y[PB-1]}}, pos_y};
    key_x   = px_ext[CB-1:0];
    key_y   = py_ext[CB-1:0];
    rx_ext  = {{PB{res_x[CB-1]}}, res_x};
    ry_ext  = {{PB{res_y[CB-1]}}, res_y};
    idx_ext = {{INDEX_BITS{1'b0}}, res_idx};
    out_free = !rsp_valid || !rsp_stall;
  end

  cts_engine #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .key_x     (key_x),
    .key_y     (key_y),
    .slot      (slot),
    .out_free  (out_free),
    .done      (done),
    .res_ctl   (res_ctl),
    .res_idx   (res_idx),
    .res_x     (res_x),
    .res_y     (res_y),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cts_mem #(
    .DEPTH (DEPTH),
    .WIDTH (2 * COORD_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response word register.
  always_ff @(posedge clk) begin
    if (done) begin
      status      <= res_ctl.status;
      found_index <= idx_ext[INDEX_BITS-1:0];
      out_x       <= rx_ext[PB-1:0];
      out_y       <= ry_ext[PB-1:0];
      is_full     <= res_ctl.full;
      is_empty    <= res_ctl.empty;
    end
  end

endmodule

### tb/tb_coordinate_table_search.sv
// Self-checking testbench for coordinate_table_search: a directed pass and a random pass,
// with a table model in the bench and random idling on both channels.
// Depends on cts_pkg and the coordinate_table_search RTL.
module tb_coordinate_table_search
  import cts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH    = 64;
  localparam int TOTAL_WORDS  = 1400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [PORT_COORD_BITS-1:0] coord_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  // One response word as the table should produce it.
  typedef struct {
    req_t    op;
    status_t status;
    index_t  idx;
    coord_t  x;
    coord_t  y;
    logic    full;
    logic    empty;
  } rsp_word_t;

  logic   clk;
  logic   rst;
  logic   req_valid;
  logic   req_stall;
  logic   [2:0] req_type;
  coord_t pos_x;
  coord_t pos_y;
  index_t slot;
  logic   rsp_valid;
  logic   rsp_stall;
  logic   [1:0] status;
  index_t found_index;
  coord_t out_x;
  coord_t out_y;
  logic   is_full;
  logic   is_empty;

  // Model of the table contents and fill count.
  coord_t tbl_x [TBL_DEPTH];
  coord_t tbl_y [TBL_DEPTH];
  int     fill_cnt;

  rsp_word_t pending_rsp[$];
  int        sent_words;
  int        mismatches;
  int        quiet_cycles;
  bit        req_idle_on;
  bit        rsp_idle_on;
  int        hold_req;

  coordinate_table_search dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .slot        (slot),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .found_index (found_index),
    .out_x       (out_x),
    .out_y       (out_y),
    .is_full     (is_full),
    .is_empty    (is_empty)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // First filled entry that holds the pair, or -1.
  function automatic int scan_table(coord_t x, coord_t y);
    for (int i = 0; i < fill_cnt && i < TBL_DEPTH; i++) begin
      if (tbl_x[i] == x && tbl_y[i] == y) return i;
    end
    return -1;
  endfunction

  // Applies one request to the table model and returns the word it should produce.
  function automatic rsp_word_t table_predict(req_t op, coord_t x, coord_t y, index_t s);
    rsp_word_t w;
    int hit;
    w.op     = op;
    w.status = ST_OK;
    w.idx    = '0;
    w.x      = -16'sd1;
    w.y      = -16'sd1;
    case (op)
      REQ_PUSH: begin
        if (fill_cnt >= TBL_DEPTH) begin
          w.status = ST_FULL;
        end else begin
          w.idx = index_t'(fill_cnt);
          tbl_x[fill_cnt] = x;
          tbl_y[fill_cnt] = y;
          fill_cnt++;
        end
      end
      REQ_GET: begin
        if (int'(s) >= fill_cnt) begin
          w.status = ST_RANGE;
        end else begin
          w.idx = s;
          w.x   = tbl_x[s];
          w.y   = tbl_y[s];
        end
      end
      REQ_PEEK: begin
        if (fill_cnt == 0) begin
          w.status = ST_RANGE;
        end else begin
          w.idx = index_t'(fill_cnt - 1);
          w.x   = tbl_x[fill_cnt - 1];
          w.y   = tbl_y[fill_cnt - 1];
        end
      end
      REQ_RM_INDEX: begin
        if (int'(s) >= fill_cnt) begin
          w.status = ST_RANGE;
        end else begin
          w.idx = s;
          tbl_x[s] = -16'sd1;
          tbl_y[s] = -16'sd1;
        end
      end
      REQ_RM_OBJECT: begin
        hit = scan_table(x, y);
        if (hit < 0) begin
          w.status = ST_RANGE;
        end else begin
          w.idx = index_t'(hit);
          tbl_x[hit] = -16'sd1;
          tbl_y[hit] = -16'sd1;
        end
      end
      REQ_FIND: begin
        hit = scan_table(x, y);
        if (hit < 0) w.status = ST_NOTFOUND;
        else w.idx = index_t'(hit);
      end
      REQ_FIRST_FREE: begin
        hit = scan_table(-16'sd1, -16'sd1);
        if (hit < 0) w.status = ST_NOTFOUND;
        else w.idx = index_t'(hit);
      end
      default: begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          tbl_x[i] = -16'sd1;
          tbl_y[i] = -16'sd1;
        end
      end
    endcase
    if (w.status != ST_OK) w.idx = '0;
    w.full  = (fill_cnt >= TBL_DEPTH);
    w.empty = (fill_cnt == 0);
    return w;
  endfunction

  // Length of one idle stretch: mostly short, now and then long.
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sends one request word, holds it until taken, then records the expected response.
  task automatic send_req(req_t op, coord_t x, coord_t y, index_t s);
    int gap;
    @(negedge clk);
    req_valid <= 1'b1;
    req_type  <= op;
    pos_x     <= x;
    pos_y     <= y;
    slot      <= s;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(table_predict(op, x, y, s));
    sent_words++;
    gap = 0;
    if (req_idle_on && $urandom_range(1) == 1) gap = pick_len();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // A coordinate pair: small values that collide often, the empty marker, extremes, or noise.
  task automatic pick_pair(output coord_t x, output coord_t y);
    coord_t extremes [4];
    int r;
    extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
    r = $urandom_range(99);
    if (r < 40) begin
      x = coord_t'($urandom_range(0, 4)) - 16'sd2;
      y = coord_t'($urandom_range(0, 4)) - 16'sd2;
    end else if (r < 55) begin
      x = -16'sd1;
      y = -16'sd1;
    end else if (r < 70) begin
      x = extremes[$urandom_range(0, 3)];
      y = extremes[$urandom_range(0, 3)];
    end else begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end
  endtask

  // One random request; lookups mostly aim at pairs that sit in the table.
  task automatic random_req(int push_pct);
    req_t   op;
    coord_t x;
    coord_t y;
    index_t s;
    if ($urandom_range(99) < push_pct) begin
      op = REQ_PUSH;
    end else begin
      op = req_t'($urandom_range(1, 7));
      if (op == REQ_CLEAR && $urandom_range(9) != 0) op = REQ_FIND;
      if ((op == REQ_RM_INDEX || op == REQ_RM_OBJECT) && $urandom_range(1) == 0) op = REQ_GET;
    end
    if (fill_cnt > 0 && $urandom_range(99) < 60) begin
      s = index_t'($urandom_range(0, fill_cnt - 1));
      x = tbl_x[s];
      y = tbl_y[s];
    end else begin
      s = index_t'($urandom_range(0, TBL_DEPTH - 1));
      pick_pair(x, y);
    end
    send_req(op, x, y, s);
  endtask

  // Every request but push on an empty table.
  task automatic test_empty_table();
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    send_req(REQ_PEEK, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_GET, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_RM_INDEX, 16'sd0, 16'sd0, 6'd63);
    send_req(REQ_RM_OBJECT, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_FIND, -16'sd1, -16'sd1, 6'd0);
    send_req(REQ_FIRST_FREE, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_CLEAR, 16'sd0, 16'sd0, 6'd0);
  endtask

  // Extreme pairs, lookups of the empty marker, removal of absent pairs and clear.
  task automatic test_directed_ops();
    send_req(REQ_PUSH, 16'sh7FFF, 16'sh8000, 6'd0);
    send_req(REQ_PUSH, 16'sh8000, 16'sh7FFF, 6'd0);
    send_req(REQ_PUSH, -16'sd1, -16'sd1, 6'd0);
    send_req(REQ_PUSH, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_GET, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_GET, 16'sd0, 16'sd0, 6'd63);
    send_req(REQ_PEEK, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_FIND, -16'sd1, -16'sd1, 6'd0);
    send_req(REQ_FIRST_FREE, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_RM_OBJECT, 16'sh7FFF, 16'sh8000, 6'd0);
    send_req(REQ_FIND, 16'sh7FFF, 16'sh8000, 6'd0);
    send_req(REQ_RM_INDEX, 16'sd0, 16'sd0, 6'd1);
    send_req(REQ_FIRST_FREE, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_RM_OBJECT, 16'sd5, 16'sd5, 6'd0);
    send_req(REQ_CLEAR, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_PEEK, 16'sd0, 16'sd0, 6'd0);
    send_req(REQ_FIND, 16'sd0, 16'sd0, 6'd0);
  endtask

  // Random traffic while the table is still filling.
  task automatic test_random_partial();
    req_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    repeat (450) random_req(12);
  endtask

  // Hold the response side for a long stretch while requests keep coming.
  task automatic test_backpressure();
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    hold_req    = HOLD_CYCLES;
    repeat (30) random_req(20);
  endtask

  // Push-heavy traffic until the table is full.
  task automatic test_fill_to_capacity();
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b1;
    while (fill_cnt < TBL_DEPTH) random_req(40);
  endtask

  // Random traffic on a full table, switching idle modes now and then.
  task automatic test_random_full();
    while (sent_words < TOTAL_WORDS) begin
      if (sent_words % 200 == 0) begin
        req_idle_on = $urandom_range(1);
        rsp_idle_on = $urandom_range(1);
      end
      random_req(10);
    end
  endtask

  // Response-side stall: long hold on request, otherwise random stall runs.
  initial begin
    int hold_left;
    int run_left;
    hold_left = 0;
    run_left  = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        rsp_stall <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(3) == 0) begin
        run_left = pick_len() - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted response word with the oldest expectation.
  always @(posedge clk) begin
    rsp_word_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: response word with nothing expected: status %0d idx %0d",
                   $realtime, status, found_index);
      end else begin
        w = pending_rsp.pop_front();
        if (status != w.status || found_index != w.idx || out_x != w.x || out_y != w.y ||
            is_full != w.full || is_empty != w.empty) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch on %s", $realtime, w.op.name());
            $display("  expected status %0d idx %0d x %0d y %0d full %b empty %b",
                     w.status, w.idx, w.x, w.y, w.full, w.empty);
            $display("  actual   status %0d idx %0d x %0d y %0d full %b empty %b",
                     status, found_index, out_x, out_y, is_full, is_empty);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_coordinate_table_search: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req_type     = REQ_PUSH;
    pos_x        = '0;
    pos_y        = '0;
    slot         = '0;
    sent_words   = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    req_idle_on  = 1'b0;
    rsp_idle_on  = 1'b0;
    hold_req     = 0;
    fill_cnt     = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_x[i] = -16'sd1;
      tbl_y[i] = -16'sd1;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed_ops();
    test_random_partial();
    test_backpressure();
    test_fill_to_capacity();
    test_random_full();

    // Drain: wait for every expected word, then allow for one more full scan.
    @(negedge clk);
    req_valid <= 1'b0;
    rsp_idle_on = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("tb_coordinate_table_search: done, clean");
    else
      $display("tb_coordinate_table_search: done, errors");
    $finish;
  end

endmodule
